// ===== design/sbdp_pkg.sv =====
`timescale 1ns / 1ps

package sbdp_pkg;

    localparam int unsigned PC_W    = 32;

    typedef enum logic [1:0] {
        MODE_NEVER   = 2'd0,
        MODE_ALWAYS  = 2'd1,
        MODE_BIMODAL = 2'd2,
        MODE_LOCAL   = 2'd3
    } mode_t;

    typedef enum logic {
        OP_PREDICT = 1'b0,
        OP_TRAIN   = 1'b1
    } op_t;

    typedef logic [1:0] ctr_t;

    localparam ctr_t CTR_MIN       = 2'd0;
    localparam ctr_t CTR_RESET     = 2'd1;
    localparam ctr_t CTR_TAKEN_MIN = 2'd2;
    localparam ctr_t CTR_MAX       = 2'd3;

    function automatic ctr_t ctr_train(ctr_t c, logic t);
        ctr_t r;
        if (t)
        begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end
        else
        begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== design/sbdp_if.sv =====
`timescale 1ns / 1ps

interface sbdp_req_if
    import sbdp_pkg::*;
();
    logic            valid;
    logic            ready;
    op_t             op;
    logic [PC_W-1:0] pc;
    logic            branch_insn;
    logic            taken;

    modport source (output valid, output op, output pc, output branch_insn, output taken,
                    input ready);
    modport sink   (input valid, input op, input pc, input branch_insn, input taken,
                    output ready);
endinterface

interface sbdp_rsp_if;
    logic valid;
    logic ready;
    logic predict_taken;

    modport source (output valid, output predict_taken, input ready);
    modport sink   (input valid, input predict_taken, output ready);
endinterface

interface sbdp_cfg_if
    import sbdp_pkg::*;
();
    logic  valid;
    logic  ready;
    mode_t predictor_mode;

    modport source (output valid, output predictor_mode, input ready);
    modport sink   (input valid, input predictor_mode, output ready);
endinterface

// ===== design/sbdp_ram.sv =====
`timescale 1ns / 1ps

module sbdp_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 256
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sbdp_mod.sv =====
`timescale 1ns / 1ps

module sbdp_mod
    import sbdp_pkg::*;
#(
    parameter int unsigned MODULUS = 256
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [PC_W-1:0]            value,
    output logic                       done,
    output logic [$clog2(MODULUS)-1:0] result
);

    localparam int unsigned RW     = $clog2(MODULUS);
    localparam bit          IS_POW2 = ((MODULUS & (MODULUS - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_mask
            logic          done_reg;
            logic [RW-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else if (start)
                begin
                    done_reg <= 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= value[RW-1:0];
                end
            end

            assign done   = done_reg;
            assign result = rem_reg;
        end
        else
        begin : g_recip
            localparam longint unsigned RECIP   = (64'd1 << PC_W) / 64'(MODULUS);
            localparam logic [PC_W-1:0] RECIP_C = PC_W'(RECIP);
            localparam logic [PC_W-1:0] MOD_C   = PC_W'(MODULUS);
            localparam logic [RW:0]     NV      = (RW + 1)'(MODULUS);

            logic              s1_reg;
            logic              s2_reg;
            logic              done_reg;
            logic [PC_W-1:0]   val_reg;
            logic [PC_W-1:0]   quo_reg;
            logic [RW:0]       diff_reg;
            logic [RW-1:0]     rem_reg;
            logic [2*PC_W-1:0] prod;
            logic [PC_W-1:0]   back;
            logic [PC_W-1:0]   diff;

            // quotient estimate is exact or one short, so one correction step follows
            assign prod = {{PC_W{1'b0}}, value} * {{PC_W{1'b0}}, RECIP_C};
            assign back = quo_reg * MOD_C;
            assign diff = val_reg - back;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    s1_reg   <= 1'b0;
                    s2_reg   <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    s1_reg <= start;
                    s2_reg <= s1_reg;
                    if (start)
                    begin
                        done_reg <= 1'b0;
                    end
                    else if (s2_reg)
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    val_reg <= value;
                    quo_reg <= prod[2*PC_W-1:PC_W];
                end
                if (s1_reg)
                begin
                    diff_reg <= diff[RW:0];
                end
                if (s2_reg)
                begin
                    rem_reg <= (diff_reg >= NV) ? RW'(diff_reg - NV) : diff_reg[RW-1:0];
                end
            end

            assign done   = done_reg;
            assign result = rem_reg;
        end
    endgenerate

endmodule

// ===== design/selectable_branch_direction_predictor_core.sv =====
`timescale 1ns / 1ps
// a predict result is registered after the index step, the history read and the pattern read;
// the pc modulo is done by reciprocal multiply in three stages unless the table size is a power of two
// a new request is taken only in idle, once the index step and the two dependent synchronous
// reads (history, then pattern counter) of the last one are through; a held result stalls
// the next predict. reset: mode never taken; a clearing pass over max(BIMODAL_ENTRIES,
// LOCAL_ENTRIES * 2**HISTORY_BITS) addresses writes the tables while requests are held off
module selectable_branch_direction_predictor_core
    import sbdp_pkg::*;
#(
    parameter int unsigned BIMODAL_ENTRIES = 256,
    parameter int unsigned LOCAL_ENTRIES   = 64,
    parameter int unsigned HISTORY_BITS    = 4
)(
    input logic        clk,
    input logic        rst_n,
    sbdp_req_if.sink   req,
    sbdp_rsp_if.source rsp,
    sbdp_cfg_if.sink   cfg
);

    localparam int unsigned BI_AW     = $clog2(BIMODAL_ENTRIES);
    localparam int unsigned LI_AW     = $clog2(LOCAL_ENTRIES);
    localparam int unsigned PAT_DEPTH = LOCAL_ENTRIES << HISTORY_BITS;
    localparam int unsigned PAT_AW    = LI_AW + HISTORY_BITS;
    localparam int unsigned CLR_DEPTH =
        (BIMODAL_ENTRIES > PAT_DEPTH) ? BIMODAL_ENTRIES : PAT_DEPTH;
    localparam int unsigned CLR_AW    = $clog2(CLR_DEPTH);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_INDEX = 5'b00100,
        S_HIST  = 5'b01000,
        S_CNT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg;
    op_t                 op_reg;
    logic                branch_insn_reg;
    logic                taken_reg;
    logic                out_valid_reg;
    logic                out_taken_reg;
    logic [CLR_AW-1:0]   clr_cnt_reg;

    logic                req_fire;
    logic                clearing;
    logic                clr_last;
    logic                clr_bim, clr_hist, clr_pat;
    logic                bi_done, li_done;
    logic [BI_AW-1:0]    bi_idx;
    logic [LI_AW-1:0]    li_idx;
    logic                cnt_go;
    logic                rsp_load;
    logic                train_now;
    logic                predict_bit;

    logic                    bim_we;
    logic [BI_AW-1:0]        bim_waddr;
    ctr_t                    bim_wdata, bim_rdata;
    logic                    hist_we;
    logic [LI_AW-1:0]        hist_waddr;
    logic [HISTORY_BITS-1:0] hist_wdata, hist_rdata;
    logic                    pat_we;
    logic [PAT_AW-1:0]       pat_waddr, pat_raddr;
    ctr_t                    pat_wdata, pat_rdata;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.predict_taken = out_taken_reg;

    sbdp_mod #(.MODULUS(BIMODAL_ENTRIES)) u_bi_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (req_fire),
        .value  (req.pc),
        .done   (bi_done),
        .result (bi_idx)
    );

    sbdp_mod #(.MODULUS(LOCAL_ENTRIES)) u_li_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (req_fire),
        .value  (req.pc),
        .done   (li_done),
        .result (li_idx)
    );

    // clearing pass
    assign clearing = (state_reg == S_CLEAR);
    assign clr_last = (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1));
    assign clr_bim  = {1'b0, clr_cnt_reg} < (CLR_AW + 1)'(BIMODAL_ENTRIES);
    assign clr_hist = {1'b0, clr_cnt_reg} < (CLR_AW + 1)'(LOCAL_ENTRIES);
    assign clr_pat  = {1'b0, clr_cnt_reg} < (CLR_AW + 1)'(PAT_DEPTH);

    // a predict result waits only for the output register to free up
    assign cnt_go    = (state_reg == S_CNT) &&
                       ((op_reg == OP_TRAIN) || !out_valid_reg || rsp.ready);
    assign rsp_load  = cnt_go && (op_reg == OP_PREDICT);
    assign train_now = cnt_go && (op_reg == OP_TRAIN);

    assign pat_raddr = {li_idx, hist_rdata};

    always_comb
    begin
        predict_bit = 1'b0;
        if (branch_insn_reg)
        begin
            unique case (mode_reg)
                MODE_NEVER:   predict_bit = 1'b0;
                MODE_ALWAYS:  predict_bit = 1'b1;
                MODE_BIMODAL: predict_bit = (bim_rdata >= CTR_TAKEN_MIN);
                MODE_LOCAL:   predict_bit = (pat_rdata >= CTR_TAKEN_MIN);
                default:      predict_bit = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        if (clearing)
        begin
            bim_we     = clr_bim;
            bim_waddr  = clr_cnt_reg[BI_AW-1:0];
            bim_wdata  = CTR_RESET;
            hist_we    = clr_hist;
            hist_waddr = clr_cnt_reg[LI_AW-1:0];
            hist_wdata = '0;
            pat_we     = clr_pat;
            pat_waddr  = clr_cnt_reg[PAT_AW-1:0];
            pat_wdata  = CTR_RESET;
        end
        else
        begin
            bim_we     = train_now && (mode_reg == MODE_BIMODAL);
            bim_waddr  = bi_idx;
            bim_wdata  = ctr_train(bim_rdata, taken_reg);
            hist_we    = train_now && (mode_reg == MODE_LOCAL);
            hist_waddr = li_idx;
            hist_wdata = HISTORY_BITS'({hist_rdata, taken_reg});
            pat_we     = train_now && (mode_reg == MODE_LOCAL);
            pat_waddr  = pat_raddr;
            pat_wdata  = ctr_train(pat_rdata, taken_reg);
        end
    end

    sbdp_ram #(.WIDTH(2), .DEPTH(BIMODAL_ENTRIES)) u_bim_ram (
        .clk   (clk),
        .we    (bim_we),
        .waddr (bim_waddr),
        .wdata (bim_wdata),
        .raddr (bi_idx),
        .rdata (bim_rdata)
    );

    sbdp_ram #(.WIDTH(HISTORY_BITS), .DEPTH(LOCAL_ENTRIES)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (li_idx),
        .rdata (hist_rdata)
    );

    sbdp_ram #(.WIDTH(2), .DEPTH(PAT_DEPTH)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_INDEX;
                end
            end
            S_INDEX:
            begin
                // indexes stable, history and bimodal reads issued
                if (bi_done && li_done)
                begin
                    state_next = S_HIST;
                end
            end
            S_HIST:
            begin
                // history back, pattern read issued
                state_next = S_CNT;
            end
            S_CNT:
            begin
                if (cnt_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= MODE_NEVER;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                mode_reg <= cfg.predictor_mode;
            end
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_AW'(1);
            end
            if (rsp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg          <= req.op;
            branch_insn_reg <= req.branch_insn;
            taken_reg       <= req.taken;
        end
        if (rsp_load)
        begin
            out_taken_reg <= predict_bit;
        end
    end

endmodule
